// ===== rtl/core/wpm_pkg.sv =====
// Shared constants, types and byte helpers for the wildcard pattern matcher.
`default_nettype none

package wpm_pkg;

  localparam int MAX_TOKENS  = 16;
  localparam int IDX_W       = $clog2(MAX_TOKENS);
  localparam int POS_W       = $clog2(MAX_TOKENS + 1);
  localparam int KIND_W      = 3;
  localparam int CHAR_W      = 8;
  localparam int OP_W        = 2;
  localparam int LEN_W       = 5;
  localparam int S_DATA_W    = 24;
  localparam int M_DATA_W    = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 5;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [OP_W-1:0] OP_TOKEN  = 2'd0;
  localparam logic [OP_W-1:0] OP_MEMBER = 2'd1;
  localparam logic [OP_W-1:0] OP_BYTE   = 2'd2;
  localparam logic [OP_W-1:0] OP_END    = 2'd3;

  localparam logic [KIND_W-1:0] KIND_LITERAL    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ANY_ONE    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ANY_RUN    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_IN_SET     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NOT_IN_SET = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IGNORE_CASE    = 1'd1;

  localparam logic [MAX_TOKENS:0] ACTIVE_RESET = (MAX_TOKENS + 1)'(1);

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  token_index;
    logic [KIND_W-1:0] token_kind;
    logic [CHAR_W-1:0] char_value;
    logic              last_byte;
    logic              has_result;
  } cmd_t;

  function automatic logic [CHAR_W-1:0] fold_lower(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c inside {[8'h41:8'h5A]}) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] swap_case(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c inside {[8'h41:8'h5A]}) begin
      r = c + 8'h20;
    end else if (c inside {[8'h61:8'h7A]}) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/wpm_queue.sv =====
// Short command queue between the front and back parts of the matcher.
`default_nettype none

module wpm_queue
  import wpm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output cmd_t      head_cmd
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue push without pop did not grow the count");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/wpm_front.sv =====
// Front part: takes input requests, classifies them and queues them.
`default_nettype none

module wpm_front
  import wpm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [S_DATA_W-1:0] s_tdata,
  input  wire logic                s_tlast,
  input  wire logic                pop,
  output logic                     head_valid,
  output cmd_t                     head_cmd
);

  cmd_t in_cmd;
  logic full;
  logic push;

  always_comb begin
    in_cmd.op          = s_tdata[1:0];
    in_cmd.token_index = s_tdata[5:2];
    in_cmd.token_kind  = s_tdata[8:6];
    in_cmd.char_value  = s_tdata[16:9];
    in_cmd.last_byte   = s_tlast;
    in_cmd.has_result  = (in_cmd.op == OP_END) || ((in_cmd.op == OP_BYTE) && s_tlast);
  end

  assign s_tready = !full;
  assign push     = s_tvalid && s_tready;

  wpm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (in_cmd),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

endmodule

`default_nettype wire

// ===== rtl/core/wpm_back.sv =====
// Back part: pattern store, active position vector and result register.
`default_nettype none

module wpm_back
  import wpm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  head_valid,
  input  wire cmd_t                  head_cmd,
  output logic                       pop,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [M_DATA_W-1:0]        m_tdata
);

  logic [LEN_W-1:0]  pattern_length;
  logic              ignore_case;
  logic [KIND_W-1:0] token_kinds [MAX_TOKENS];
  logic [CHAR_W-1:0] token_bytes [MAX_TOKENS];
  logic [255:0]      set_masks   [MAX_TOKENS];
  logic [MAX_TOKENS:0] active;
  logic              matched;

  logic [POS_W-1:0]    len;
  logic [MAX_TOKENS-1:0] in_use;
  logic [MAX_TOKENS-1:0] run;
  logic [MAX_TOKENS-1:0] hit;
  logic [MAX_TOKENS:0] closed;
  logic [MAX_TOKENS:0] stepped;
  logic [MAX_TOKENS:0] stepped_closed;
  logic [CHAR_W-1:0]   ch;
  logic [CHAR_W-1:0]   ch_swapped;
  logic                set_hit;
  logic                verdict;

  assign pop = head_valid && (!m_tvalid || m_tready);
  assign ch  = head_cmd.char_value;
  assign ch_swapped = swap_case(ch);
  assign m_tdata = {(M_DATA_W - 1)'(0), matched};

  always_comb begin
    if (pattern_length > LEN_W'(MAX_TOKENS)) begin
      len = POS_W'(MAX_TOKENS);
    end else begin
      len = POS_W'(pattern_length);
    end
    set_hit = 1'b0;
    for (int p = 0; p < MAX_TOKENS; p++) begin
      in_use[p] = (POS_W'(p) < len);
      run[p]    = in_use[p] && (token_kinds[p] == KIND_ANY_RUN);
      set_hit   = set_masks[p][ch] || (ignore_case && set_masks[p][ch_swapped]);
      case (token_kinds[p])
        KIND_LITERAL: begin
          hit[p] = ignore_case ? (fold_lower(token_bytes[p]) == fold_lower(ch))
                               : (token_bytes[p] == ch);
        end
        KIND_ANY_ONE:    hit[p] = 1'b1;
        KIND_IN_SET:     hit[p] = set_hit;
        KIND_NOT_IN_SET: hit[p] = !set_hit;
        default:         hit[p] = 1'b0;
      endcase
    end
    // A live run token also makes the position after it live.
    closed[0] = active[0];
    for (int p = 0; p < MAX_TOKENS; p++) begin
      closed[p+1] = active[p+1] || (closed[p] && run[p]);
    end
    stepped = '0;
    for (int p = 0; p < MAX_TOKENS; p++) begin
      if (closed[p] && run[p]) begin
        stepped[p] = 1'b1;
      end
      if (closed[p] && in_use[p] && !run[p] && hit[p]) begin
        stepped[p+1] = 1'b1;
      end
    end
    stepped_closed[0] = stepped[0];
    for (int p = 0; p < MAX_TOKENS; p++) begin
      stepped_closed[p+1] = stepped[p+1] || (stepped_closed[p] && run[p]);
    end
    verdict = (head_cmd.op == OP_END) ? closed[len] : stepped_closed[len];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      ignore_case    <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PATTERN_LENGTH: pattern_length <= cfg_wdata[LEN_W-1:0];
        REG_IGNORE_CASE:    ignore_case    <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (head_cmd.op == OP_TOKEN)) begin
      token_kinds[head_cmd.token_index] <= head_cmd.token_kind;
      token_bytes[head_cmd.token_index] <= head_cmd.char_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < MAX_TOKENS; p++) begin
        set_masks[p] <= '0;
      end
    end else if (pop) begin
      case (head_cmd.op)
        OP_TOKEN:  set_masks[head_cmd.token_index] <= '0;
        OP_MEMBER: set_masks[head_cmd.token_index][head_cmd.char_value] <= 1'b1;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= ACTIVE_RESET;
    end else if (pop) begin
      case (head_cmd.op)
        OP_BYTE:  active <= head_cmd.last_byte ? ACTIVE_RESET : stepped;
        OP_END:   active <= ACTIVE_RESET;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop && head_cmd.has_result) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_cmd.has_result) begin
      matched <= verdict;
    end
  end

`ifndef SYNTH
  a_rearm: assert property (@(posedge clk) disable iff (rst)
    pop && head_cmd.has_result |=> active == ACTIVE_RESET)
    else $error("matcher not rearmed after a verdict");
  a_verdict_shown: assert property (@(posedge clk) disable iff (rst)
    pop && head_cmd.has_result |=> m_tvalid)
    else $error("verdict request produced no result");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/wildcard_pattern_matcher_unit.sv =====
// Top level of the wildcard pattern matcher.
//
// Requests arrive on the s_ stream: tdata carries op, token index, token
// kind and byte, tlast marks the final subject byte. Token and set member
// requests load the pattern; subject byte requests advance the vector of
// live pattern positions; the final byte, or an end request, gives a verdict.
// Verdicts leave on the m_ stream, one byte of tdata with the match in bit 0.
// Registers pattern_length and ignore_case are written through cfg_wr_en,
// cfg_index and cfg_wdata; the user must write them only while no request is
// in flight, which the block itself does not enforce. One request is taken
// every cycle while s_tready is high; all token positions are updated at
// once from the pattern store. The accepting edge writes a request into the
// four-entry queue; once it is at the queue head and the result register is
// free, it is taken and its verdict is loaded into the result register.
// Reset clears the registers, the set masks, the queue and the result, and
// leaves only position zero live; token kinds and bytes hold no value until
// written. When the receiver stalls, the verdict waits in the result register,
// no request leaves the queue, and the queue goes on taking requests until it
// is full.
`default_nettype none

module wildcard_pattern_matcher_unit
  import wpm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // op [1:0], token_index [5:2], token_kind [8:6], char_value [16:9]
  input  wire logic [S_DATA_W-1:0]   s_tdata,
  input  wire logic                  s_tlast,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // matched [0]
  output logic [M_DATA_W-1:0]        m_tdata,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic pop;
  logic head_valid;
  cmd_t head_cmd;

  wpm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  wpm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

`default_nettype wire

// ===== tb/sv/match_verdict_checker.sv =====
`timescale 1ns / 100ps
// Checker that watches the matcher's streams, predicts every verdict and compares.
module match_verdict_checker
  import wpm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  input  wire logic                  s_tready,
  // op [1:0], token_index [5:2], token_kind [8:6], char_value [16:9]
  input  wire logic [S_DATA_W-1:0]   s_tdata,
  input  wire logic                  s_tlast,
  input  wire logic                  m_tvalid,
  input  wire logic                  m_tready,
  // matched [0]
  input  wire logic [M_DATA_W-1:0]   m_tdata,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                         verdicts_pending,
  output int                         fail_count
);

  logic [KIND_W-1:0] tok_kind [MAX_TOKENS];
  logic [CHAR_W-1:0] tok_byte [MAX_TOKENS];
  logic [255:0]      tok_set  [MAX_TOKENS];
  logic [MAX_TOKENS:0] live;
  logic [LEN_W-1:0]  cur_len;
  logic              fold_on;
  bit                verdicts_due [$];

  function automatic bit is_letter(input logic [CHAR_W-1:0] c);
    return ((c | 8'h20) >= 8'h61) && ((c | 8'h20) <= 8'h7A);
  endfunction

  function automatic bit set_holds(input int p, input logic [CHAR_W-1:0] c);
    return tok_set[p][c] || (fold_on && is_letter(c) && tok_set[p][c ^ 8'h20]);
  endfunction

  function automatic bit accepts(input int p, input logic [CHAR_W-1:0] c);
    case (tok_kind[p])
      KIND_LITERAL: begin
        if (fold_on && is_letter(tok_byte[p]) && is_letter(c)) begin
          return (tok_byte[p] | 8'h20) == (c | 8'h20);
        end
        return tok_byte[p] == c;
      end
      KIND_ANY_ONE:    return 1'b1;
      KIND_IN_SET:     return set_holds(p, c);
      KIND_NOT_IN_SET: return !set_holds(p, c);
      default:         return 1'b0;
    endcase
  endfunction

  // A live run token also makes the position after it live.
  function automatic void close_runs(input int len);
    int p;
    for (p = 0; p < len; p++) begin
      if (live[p] && tok_kind[p] == KIND_ANY_RUN) begin
        live[p + 1] = 1'b1;
      end
    end
  endfunction

  task automatic advance_matcher(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                                 input logic [KIND_W-1:0] kind,
                                 input logic [CHAR_W-1:0] ch, input logic last,
                                 output bit gives, output bit verdict);
    int len;
    int p;
    logic [MAX_TOKENS:0] nxt;
    gives = 1'b0;
    verdict = 1'b0;
    len = (cur_len > MAX_TOKENS) ? MAX_TOKENS : int'(cur_len);
    case (op)
      OP_TOKEN: begin
        tok_kind[idx] = kind;
        tok_byte[idx] = ch;
        tok_set[idx] = '0;
      end
      OP_MEMBER: tok_set[idx][ch] = 1'b1;
      default: begin
        if (op == OP_BYTE) begin
          close_runs(len);
          nxt = '0;
          for (p = 0; p < len; p++) begin
            if (live[p]) begin
              if (tok_kind[p] == KIND_ANY_RUN) begin
                nxt[p] = 1'b1;
              end else if (accepts(p, ch)) begin
                nxt[p + 1] = 1'b1;
              end
            end
          end
          live = nxt;
        end
        if (op == OP_END || last) begin
          close_runs(len);
          gives = 1'b1;
          verdict = live[len];
          live = (MAX_TOKENS + 1)'(1);
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    bit gives;
    bit verdict;
    int i;
    if (rst) begin
      for (i = 0; i < MAX_TOKENS; i++) begin
        tok_kind[i] = '0;
        tok_byte[i] = '0;
        tok_set[i] = '0;
      end
      cur_len = '0;
      fold_on = 1'b0;
      live = (MAX_TOKENS + 1)'(1);
      verdicts_due.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_PATTERN_LENGTH: cur_len = cfg_wdata[LEN_W-1:0];
          REG_IGNORE_CASE:    fold_on = cfg_wdata[0];
          default:            ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        advance_matcher(s_tdata[1:0], s_tdata[5:2], s_tdata[8:6], s_tdata[16:9], s_tlast,
                        gives, verdict);
        if (gives) begin
          verdicts_due.push_back(verdict);
        end
      end
      if (m_tvalid && m_tready) begin
        if (verdicts_due.size() == 0) begin
          $error("unexpected verdict, m_tdata %h", m_tdata);
          fail_count = fail_count + 1;
        end else begin
          verdict = verdicts_due.pop_front();
          if (m_tdata[0] !== verdict) begin
            $error("matched: expected %0b, actual %0b", verdict, m_tdata[0]);
            fail_count = fail_count + 1;
          end
          if (m_tdata[M_DATA_W-1:1] !== '0) begin
            $error("m_tdata padding: expected 0, actual %h", m_tdata[M_DATA_W-1:1]);
            fail_count = fail_count + 1;
          end
        end
      end
    end
    verdicts_pending <= verdicts_due.size();
  end

endmodule

// ===== tb/sv/wildcard_pattern_matcher_unit_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the wildcard pattern matcher: clock, reset, requests and the verdict.
module wildcard_pattern_matcher_unit_tb;
  import wpm_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE_LOW  = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_HIGH = 3'd7;
  localparam int LONG_HOLD     = 80;
  localparam int SETTLE_CYCLES = 10;
  localparam int PHASE_ITEMS   = 80;
  localparam int PHASES        = 9;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata;
  logic                  s_tlast;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [M_DATA_W-1:0]   m_tdata;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    verdicts_pending;
  int                    fail_count;

  logic [KIND_W-1:0] pat_kind    [MAX_TOKENS];
  logic [CHAR_W-1:0] pat_byte    [MAX_TOKENS];
  logic [255:0]      pat_set     [MAX_TOKENS];
  logic [CHAR_W-1:0] pat_members [MAX_TOKENS][8];
  int                pat_member_count [MAX_TOKENS];
  int                cur_len;
  bit                cur_fold;
  int                sent = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  wildcard_pattern_matcher_unit dut (.*);

  match_verdict_checker verdict_check (.*);

  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                              input logic [KIND_W-1:0] kind, input logic [CHAR_W-1:0] ch,
                              input logic last);
    int gap;
    gap = (sent % 100 < 25) ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(S_DATA_W - 17){1'b0}}, ch, kind, idx, op};
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  task automatic send_random(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                             input logic last);
    send_request(op, IDX_W'($urandom_range(0, 15)), KIND_W'($urandom_range(0, 7)), ch, last);
  endtask

  task automatic load_token(input int idx, input logic [KIND_W-1:0] kind,
                            input logic [CHAR_W-1:0] ch);
    pat_kind[idx] = kind;
    pat_byte[idx] = ch;
    pat_set[idx] = '0;
    pat_member_count[idx] = 0;
    send_request(OP_TOKEN, IDX_W'(idx), kind, ch, 1'($urandom_range(0, 1)));
  endtask

  task automatic add_member(input int idx, input logic [CHAR_W-1:0] ch);
    pat_set[idx][ch] = 1'b1;
    if (pat_member_count[idx] < 8) begin
      pat_members[idx][pat_member_count[idx]] = ch;
      pat_member_count[idx]++;
    end
    send_request(OP_MEMBER, IDX_W'(idx), KIND_W'($urandom_range(0, 7)), ch,
                 1'($urandom_range(0, 1)));
  endtask

  function automatic logic [CHAR_W-1:0] pick_char();
    int r;
    logic [CHAR_W-1:0] c;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      c = 8'(8'h41 + $urandom_range(0, 25));
      if ($urandom_range(0, 1) == 1) begin
        c = c | 8'h20;
      end
      return c;
    end
    if (r < 8) begin
      return 8'($urandom_range(8'h20, 8'h7E));
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic load_random_token(input int idx);
    int r;
    logic [KIND_W-1:0] kind;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      kind = KIND_LITERAL;
    end else if (r < 50) begin
      kind = KIND_ANY_ONE;
    end else if (r < 68) begin
      kind = KIND_ANY_RUN;
    end else if (r < 81) begin
      kind = KIND_IN_SET;
    end else if (r < 94) begin
      kind = KIND_NOT_IN_SET;
    end else begin
      kind = KIND_W'($urandom_range(KIND_SPARE_LOW, KIND_SPARE_HIGH));
    end
    load_token(idx, kind, pick_char());
    if (kind == KIND_IN_SET || kind == KIND_NOT_IN_SET) begin
      repeat ($urandom_range(1, 5)) add_member(idx, pick_char());
    end
  endtask

  // Most subjects follow the loaded pattern so that the live positions get deep;
  // some are bent or cut short, and some are plain noise.
  task automatic send_subject();
    logic [CHAR_W-1:0] subj [$];
    logic [CHAR_W-1:0] c;
    int r;
    int k;
    bit cut;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      repeat ($urandom_range(0, 6)) subj.push_back(8'($urandom_range(0, 255)));
    end else begin
      for (k = 0; k < cur_len && k < MAX_TOKENS; k++) begin
        case (pat_kind[k])
          KIND_LITERAL: begin
            c = pat_byte[k];
            if (cur_fold && (c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7A &&
                $urandom_range(0, 1) == 1) begin
              c = c ^ 8'h20;
            end
            subj.push_back(c);
          end
          KIND_ANY_RUN: repeat ($urandom_range(0, 3)) subj.push_back(pick_char());
          KIND_IN_SET: begin
            if (pat_member_count[k] > 0) begin
              subj.push_back(pat_members[k][$urandom_range(0, pat_member_count[k] - 1)]);
            end else begin
              subj.push_back(pick_char());
            end
          end
          KIND_NOT_IN_SET: begin
            c = pick_char();
            repeat (16) begin
              if (pat_set[k][c] || pat_set[k][c ^ 8'h20]) begin
                c = 8'($urandom_range(0, 255));
              end
            end
            subj.push_back(c);
          end
          default: subj.push_back(8'($urandom_range(0, 255)));
        endcase
      end
      if (r < 35 && subj.size() > 0) begin
        k = $urandom_range(0, subj.size() - 1);
        case ($urandom_range(0, 2))
          0:       subj[k] = 8'($urandom_range(0, 255));
          1:       subj.delete(k);
          default: subj.insert(k, pick_char());
        endcase
      end
    end
    if (subj.size() == 0) begin
      send_random(OP_END, pick_char(), 1'($urandom_range(0, 1)));
    end else begin
      cut = subj.size() > 1 && $urandom_range(0, 9) == 0;
      for (k = 0; k < subj.size(); k++) begin
        send_random(OP_BYTE, subj[k], !cut && k == subj.size() - 1);
      end
      if (cut) begin
        send_random(OP_END, pick_char(), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (verdicts_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_registers(input int plen, input bit fold);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_PATTERN_LENGTH;
    cfg_wdata <= CFG_DATA_W'(plen);
    @(posedge clk);
    cfg_index <= REG_IGNORE_CASE;
    cfg_wdata <= {4'($urandom_range(0, 15)), fold};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_len = plen;
    cur_fold = fold;
  endtask

  initial begin
    int hold;
    int got;
    got = 0;
    m_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (got == 15 || got == 60 || got == 120) begin
        hold = LONG_HOLD;
      end else if (got % 64 < 16) begin
        hold = 0;
      end else begin
        hold = $urandom_range(0, 8);
      end
      if (hold > 0) begin
        m_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got++;
    end
  end

  initial begin
    int phase;
    int plen;
    int start;
    int r;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tlast <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Empty pattern: only the empty subject matches.
    set_registers(0, 1'b0);
    send_request(OP_END, 4'h0, KIND_LITERAL, 8'h00, 1'b0);
    send_request(OP_BYTE, 4'hF, KIND_SPARE_HIGH, 8'h61, 1'b1);
    settle();

    set_registers(5, 1'b1);
    load_token(0, KIND_LITERAL, 8'h41);
    load_token(1, KIND_IN_SET, 8'h00);
    add_member(1, 8'h78);
    add_member(1, 8'h00);
    add_member(1, 8'hFF);
    load_token(2, KIND_ANY_RUN, 8'h2A);
    load_token(3, KIND_NOT_IN_SET, 8'h00);
    add_member(3, 8'h71);
    load_token(4, KIND_ANY_ONE, 8'h3F);
    // Folded literal, NUL as a set member, folded set miss inside the run.
    send_request(OP_BYTE, 4'h0, KIND_LITERAL, 8'h61, 1'b0);
    send_request(OP_BYTE, 4'hF, KIND_SPARE_HIGH, 8'h00, 1'b0);
    send_request(OP_BYTE, 4'h0, KIND_LITERAL, 8'h51, 1'b0);
    send_request(OP_BYTE, 4'hF, KIND_SPARE_HIGH, 8'h7A, 1'b0);
    send_request(OP_BYTE, 4'h0, KIND_LITERAL, 8'hFF, 1'b1);
    // String ended early by an end request.
    send_request(OP_BYTE, 4'h5, KIND_IN_SET, 8'h41, 1'b0);
    send_request(OP_END, 4'hA, KIND_ANY_RUN, 8'hFF, 1'b1);
    // A token of an unused kind accepts nothing.
    load_token(4, KIND_SPARE_HIGH, 8'hFF);
    send_request(OP_BYTE, 4'h0, KIND_LITERAL, 8'h41, 1'b0);
    send_request(OP_BYTE, 4'h0, KIND_LITERAL, 8'hFF, 1'b0);
    send_request(OP_BYTE, 4'h0, KIND_LITERAL, 8'h80, 1'b1);
    settle();

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       plen = MAX_TOKENS;
        1:       plen = 31;
        2:       plen = 1;
        3:       plen = $urandom_range(2, 15);
        4:       plen = 0;
        5:       plen = $urandom_range(17, 30);
        6:       plen = $urandom_range(2, 8);
        7:       plen = MAX_TOKENS;
        default: plen = $urandom_range(0, 31);
      endcase
      set_registers(plen, phase[0]);
      for (r = 0; r < MAX_TOKENS; r++) begin
        load_random_token(r);
      end
      start = sent;
      while (sent - start < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          load_random_token($urandom_range(0, MAX_TOKENS - 1));
        end else if (r < 7) begin
          add_member($urandom_range(0, MAX_TOKENS - 1), pick_char());
        end else if (r < 12) begin
          send_random($urandom_range(0, 1) ? OP_BYTE : OP_END, 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
        end else begin
          send_subject();
        end
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
